// ===== rtl/torq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp-ordered request queue package
// Shared types, codes and defaults for the request queue block.
// ----------------------------------------------------------------------------
package torq_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ACTION_W   = 2;
  localparam int QSEL_IN_W  = 2;
  localparam int ID_W       = 8;
  localparam int TS_W       = 32;
  localparam int POSITION_W = 5;
  localparam int COUNT_W    = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // One stored request: direction is the most significant sort key.
  typedef struct packed {
    logic            dir;
    logic [TS_W-1:0] ts;
    logic [ID_W-1:0] id;
  } entry_t;

  // True when entry a must stand before entry b in a queue.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.dir != b.dir) begin
      res = (a.dir < b.dir);
    end else if (a.ts != b.ts) begin
      res = (a.ts < b.ts);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

// ===== rtl/torq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module torq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/timestamp_ordered_request_queue.sv =====
// ----------------------------------------------------------------------------
// Timestamp-ordered request queue
// Several sorted request queues in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one operation (insert, pop head,
// remove by id, query id) for one queue; each produces exactly one result
// transaction with a status, the query answer, the new head id and the fill.
// Queues are sorted by direction, then timestamp, then id; equal keys keep
// arrival order. Entries live in one RAM with a registered read, so the
// sequencer reads each entry it visits and then compares or moves it: an
// insert walks from the tail, a remove or query walks from the head to the
// match and a remove then shifts the rest down. in_tready is low while an
// operation is in progress. The result sits in an output register, so a new
// operation may be taken while the last result waits; a stalled receiver
// only holds the block at the end of the following operation. Reset empties
// all queues and sets the capacity limit to 1; no clearing pass is needed
// since only filled entries are ever used. cfg_wr_en writes the capacity
// limit; the user must write it only while idle, as the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue #(
  parameter int NUM_QUEUES  = torq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = torq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // action [1:0], queue_select [3:2]
  input  logic [3:0]  in_tuser,
  // node_id [7:0], timestamp [39:8], direction [40], zero [47:41]
  input  logic [47:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status [1:0], position [6:2], is_head [7], within_capacity [8],
  // head_id [16:9], entry_count [21:17], zero [23:22]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int TOTAL   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(torq_pkg::entry_t);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_INS_RD  = 10'b00_0000_0010,
    S_INS_CMP = 10'b00_0000_0100,
    S_INS_PUT = 10'b00_0000_1000,
    S_FND_RD  = 10'b00_0001_0000,
    S_FND_CMP = 10'b00_0010_0000,
    S_SHF_RD  = 10'b00_0100_0000,
    S_SHF_WR  = 10'b00_1000_0000,
    S_HD_RD   = 10'b01_0000_0000,
    S_HD_OUT  = 10'b10_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  torq_pkg::action_t        act_r, act_nxt;
  torq_pkg::status_t        status_r, status_nxt;
  torq_pkg::entry_t         new_r, new_nxt;
  logic [QW-1:0]            q_r, q_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic                     hit_r, hit_nxt;
  logic [torq_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]         fill_r [NUM_QUEUES];

  logic                     out_valid_r;
  logic [23:0]              out_data_r;

  logic                     fill_we;
  logic [CNT_W-1:0]         fill_wd;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  torq_pkg::entry_t         ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]       ram_rdata_raw;

  logic                     accept;
  logic [4:0]               qsel_mod;
  logic [QW-1:0]            q_in;
  logic [CNT_W-1:0]         n_in;
  logic                     out_load;
  logic [31:0]              pos_ext, cnt_ext;
  logic [23:0]              out_word;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_HD_OUT) && (!out_valid_r || out_tready);

  // Queue select folded into range; a few compare and subtract steps suffice.
  always_comb begin
    qsel_mod = 5'(in_tuser[3:2]);
    for (int k = 0; k < 3; k++) begin
      if (qsel_mod >= 5'(NUM_QUEUES)) begin
        qsel_mod = qsel_mod - 5'(NUM_QUEUES);
      end
    end
  end

  assign q_in = QW'(qsel_mod);
  assign n_in = fill_r[q_in];

  assign ram_rdata = torq_pkg::entry_t'(ram_rdata_raw);

  torq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    status_nxt = status_r;
    new_nxt    = new_r;
    q_nxt      = q_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    fill_we    = 1'b0;
    fill_wd    = n_r;
    ram_we     = 1'b0;
    ram_waddr  = base_r + AW'(idx_r);
    ram_wdata  = new_r;
    ram_re     = 1'b0;
    ram_raddr  = base_r + AW'(idx_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt    = torq_pkg::action_t'(in_tuser[1:0]);
          new_nxt.id = in_tdata[7:0];
          new_nxt.ts = in_tdata[39:8];
          new_nxt.dir = in_tdata[40];
          q_nxt      = q_in;
          base_nxt   = AW'(32'(q_in) * 32'(QUEUE_DEPTH));
          n_nxt      = n_in;
          hit_nxt    = 1'b0;
          pos_nxt    = '0;
          status_nxt = torq_pkg::ST_OK;
          idx_nxt    = '0;
          if (torq_pkg::action_t'(in_tuser[1:0]) == torq_pkg::ACT_INSERT) begin
            if (n_in >= CNT_W'(QUEUE_DEPTH)) begin
              status_nxt = torq_pkg::ST_FULL;
              state_nxt  = S_HD_RD;
            end else begin
              idx_nxt   = n_in;
              state_nxt = (n_in == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else if (n_in == '0) begin
            status_nxt = torq_pkg::ST_EMPTY;
            state_nxt  = S_HD_RD;
          end else if (torq_pkg::action_t'(in_tuser[1:0]) == torq_pkg::ACT_POP) begin
            state_nxt = S_SHF_RD;
          end else begin
            state_nxt = S_FND_RD;
          end
        end
      end

      // Insertion walks from the tail, moving larger entries up by one.
      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = base_r + AW'(idx_r - CNT_W'(1));
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (torq_pkg::goes_before(new_r, ram_rdata)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CNT_W'(1);
          state_nxt = (idx_r == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = new_r;
        fill_we   = 1'b1;
        fill_wd   = n_r + CNT_W'(1);
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = S_HD_RD;
      end

      S_FND_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_FND_CMP;
      end

      S_FND_CMP: begin
        if (ram_rdata.id == new_r.id) begin
          if (act_r == torq_pkg::ACT_QUERY) begin
            hit_nxt   = 1'b1;
            pos_nxt   = idx_r;
            state_nxt = S_HD_RD;
          end else begin
            state_nxt = S_SHF_RD;
          end
        end else if ((idx_r + CNT_W'(1)) >= n_r) begin
          status_nxt = torq_pkg::ST_NOTFOUND;
          state_nxt  = S_HD_RD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FND_RD;
        end
      end

      // Close the gap at idx by moving every later entry down by one.
      S_SHF_RD: begin
        if ((idx_r + CNT_W'(1)) < n_r) begin
          ram_re    = 1'b1;
          ram_raddr = base_r + AW'(idx_r + CNT_W'(1));
          state_nxt = S_SHF_WR;
        end else begin
          fill_we   = 1'b1;
          fill_wd   = n_r - CNT_W'(1);
          n_nxt     = n_r - CNT_W'(1);
          state_nxt = S_HD_RD;
        end
      end

      S_SHF_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_SHF_RD;
      end

      S_HD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = base_r;
        state_nxt = S_HD_OUT;
      end

      S_HD_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(n_r);

  always_comb begin
    out_word        = '0;
    out_word[1:0]   = status_r;
    out_word[6:2]   = hit_r ? pos_ext[4:0] : 5'd0;
    out_word[7]     = hit_r && (pos_r == '0);
    out_word[8]     = hit_r && (pos_ext < 32'(cap_r));
    out_word[16:9]  = (n_r != '0) ? ram_rdata.id : 8'd0;
    out_word[21:17] = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= torq_pkg::CAP_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (fill_we) begin
        fill_r[q_r] <= fill_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    status_r <= status_nxt;
    new_r    <= new_nxt;
    q_r      <= q_nxt;
    base_r   <= base_nxt;
    idx_r    <= idx_nxt;
    n_r      <= n_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
